@@ hw/rtl/lbcp_pkg.sv @@
`timescale 1ns / 1ps

package lbcp_pkg;

  localparam int BLK_W    = 15;
  localparam int IDX_W    = 5;
  localparam int MAP_WORD = 32;
  localparam int MAP_SH   = 5;

  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_FLUSH = 2'd2;

  typedef struct packed {
    logic [1:0]       op;
    logic [BLK_W-1:0] block_number;
  } lbcp_in_t;

  typedef struct packed {
    logic             zero_fill;
    logic             hit;
    logic [IDX_W-1:0] entry_index;
    logic             fetch;
    logic             write_back;
    logic [BLK_W-1:0] write_back_block;
    logic             last;
  } lbcp_out_t;

endpackage

@@ hw/rtl/lbcp_touch_map.sv @@
`timescale 1ns / 1ps

module lbcp_touch_map import lbcp_pkg::*; #(
  parameter int ROWS = 1024,
  localparam int RW = $clog2(ROWS)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  output logic                busy_o,
  input  logic                rd_en_i,
  input  logic [RW-1:0]       rd_addr_i,
  output logic [MAP_WORD-1:0] rd_data_o,
  input  logic                wr_en_i,
  input  logic [RW-1:0]       wr_addr_i,
  input  logic [MAP_WORD-1:0] wr_data_i
);

  logic [MAP_WORD-1:0] mem_q [ROWS];
  logic [MAP_WORD-1:0] rd_q;
  logic                busy_q;
  logic [RW-1:0]       clr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      clr_q  <= '0;
    end else if (busy_q) begin
      clr_q <= clr_q + RW'(1);
      if (clr_q == RW'(ROWS - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      mem_q[clr_q] <= '0;
    end else if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  assign busy_o    = busy_q;
  assign rd_data_o = rd_q;

endmodule

@@ hw/rtl/lbcp_entry_ram.sv @@
`timescale 1ns / 1ps

module lbcp_entry_ram import lbcp_pkg::*; #(
  parameter int ENTRIES = 20,
  parameter int COUNT_BITS = 16,
  localparam int IW = $clog2(ENTRIES)
) (
  input  logic                  clk_i,
  input  logic                  rd_en_i,
  input  logic [IW-1:0]         rd_addr_i,
  output logic [BLK_W-1:0]      rd_blk_o,
  output logic [COUNT_BITS-1:0] rd_cnt_o,
  input  logic                  wr_en_i,
  input  logic [IW-1:0]         wr_addr_i,
  input  logic [BLK_W-1:0]      wr_blk_i,
  input  logic [COUNT_BITS-1:0] wr_cnt_i
);

  logic [BLK_W+COUNT_BITS-1:0] mem_q [ENTRIES];
  logic [BLK_W+COUNT_BITS-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= {wr_blk_i, wr_cnt_i};
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_blk_o = rd_q[BLK_W+COUNT_BITS-1:COUNT_BITS];
  assign rd_cnt_o = rd_q[COUNT_BITS-1:0];

endmodule

@@ hw/rtl/lbcp_victim_unit.sv @@
`timescale 1ns / 1ps

module lbcp_victim_unit import lbcp_pkg::*; #(
  parameter int ENTRIES = 20,
  parameter int COUNT_BITS = 16,
  localparam int IW = $clog2(ENTRIES)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic                  step_i,
  input  logic [IW-1:0]         idx_i,
  input  logic                  ent_valid_i,
  input  logic                  ent_dirty_i,
  input  logic [BLK_W-1:0]      ent_blk_i,
  input  logic [COUNT_BITS-1:0] ent_cnt_i,
  input  logic [BLK_W-1:0]      blk_i,
  output logic                  hit_o,
  output logic [IW-1:0]         hit_idx_o,
  output logic [COUNT_BITS-1:0] hit_cnt_o,
  output logic [IW-1:0]         vic_idx_o,
  output logic                  vic_wb_o,
  output logic [BLK_W-1:0]      vic_blk_o
);

  logic                  hit_q;
  logic                  cl_found_q;
  logic                  al_found_q;
  logic [IW-1:0]         hit_idx_q;
  logic [COUNT_BITS-1:0] hit_cnt_q;
  logic [IW-1:0]         cl_idx_q;
  logic [COUNT_BITS-1:0] cl_cnt_q;
  logic [IW-1:0]         al_idx_q;
  logic [COUNT_BITS-1:0] al_cnt_q;
  logic [BLK_W-1:0]      al_blk_q;
  logic                  take_hit;
  logic                  take_cl;
  logic                  take_al;

  assign take_hit = step_i && !hit_q && ent_valid_i && (ent_blk_i == blk_i);
  assign take_cl  = step_i && !ent_dirty_i && (!cl_found_q || (cl_cnt_q > ent_cnt_i));
  assign take_al  = step_i && (!al_found_q || (al_cnt_q > ent_cnt_i));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q      <= 1'b0;
      cl_found_q <= 1'b0;
      al_found_q <= 1'b0;
    end else if (start_i) begin
      hit_q      <= 1'b0;
      cl_found_q <= 1'b0;
      al_found_q <= 1'b0;
    end else begin
      if (take_hit) hit_q <= 1'b1;
      if (take_cl)  cl_found_q <= 1'b1;
      if (take_al)  al_found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_hit) begin
      hit_idx_q <= idx_i;
      hit_cnt_q <= ent_cnt_i;
    end
    if (take_cl) begin
      cl_idx_q <= idx_i;
      cl_cnt_q <= ent_cnt_i;
    end
    if (take_al) begin
      al_idx_q <= idx_i;
      al_cnt_q <= ent_cnt_i;
      al_blk_q <= ent_blk_i;
    end
  end

  assign hit_o     = hit_q;
  assign hit_idx_o = hit_idx_q;
  assign hit_cnt_o = hit_cnt_q;
  assign vic_idx_o = cl_found_q ? cl_idx_q : al_idx_q;
  assign vic_wb_o  = !cl_found_q;
  assign vic_blk_o = al_blk_q;

endmodule

@@ hw/rtl/lfu_block_cache_policy.sv @@
`timescale 1ns / 1ps

// Replacement policy for a fully associative write-back block cache: the clean
// entry with the least use count is evicted, or the least-used entry of all
// when every entry is dirty. A read or write is accepted, looks up the touched
// bitmap, streams the entry RAM through the hit/victim compare unit one entry
// per cycle, then updates and emits. A first-ever read answers zero-fill. A
// flush is accepted, then walks the entries up to the last dirty one (every
// entry when none is dirty) and emits a write-back for each dirty entry.
// Requests with op 3 or a block at or above BLOCKS are dropped. A result held
// by a stalled output holds back the next one. After reset the touched bitmap
// is swept to zero with stall high.
module lfu_block_cache_policy import lbcp_pkg::*; #(
  parameter int ENTRIES = 20,
  parameter int BLOCKS = 32768,
  parameter int COUNT_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  lbcp_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output lbcp_out_t out_data_o
);

  localparam int IW   = $clog2(ENTRIES);
  localparam int CW   = $clog2(ENTRIES + 1);
  localparam int ROWS = (BLOCKS + MAP_WORD - 1) / MAP_WORD;
  localparam int RW   = $clog2(ROWS);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_TOUCH  = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_DECIDE = 3'd4;
  localparam logic [2:0] S_FRD    = 3'd5;
  localparam logic [2:0] S_FOUT   = 3'd6;

  logic [2:0]            state_q, state_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [ENTRIES-1:0]    valid_q, valid_d;
  logic [ENTRIES-1:0]    dirty_q, dirty_d;
  logic [1:0]            op_q;
  logic [BLK_W-1:0]      blk_q;
  logic                  p_q;
  logic [IW-1:0]         p_idx_q;
  logic                  out_valid_q;
  lbcp_out_t             out_q, out_d;
  logic                  out_load;
  logic                  out_free;
  logic                  in_fire;
  logic                  in_ok;
  logic [IW-1:0]         idx;
  logic                  dirty_above;

  logic                  tm_busy;
  logic                  tm_rd_en;
  logic [MAP_WORD-1:0]   tm_rd;
  logic                  tm_wr_en;
  logic [MAP_WORD-1:0]   tm_wr_data;
  logic                  tm_bit;

  logic                  er_rd_en;
  logic [BLK_W-1:0]      er_rd_blk;
  logic [COUNT_BITS-1:0] er_rd_cnt;
  logic                  er_wr_en;
  logic [IW-1:0]         er_wr_addr;
  logic [COUNT_BITS-1:0] er_wr_cnt;

  logic                  vu_start;
  logic                  vu_hit;
  logic [IW-1:0]         vu_hit_idx;
  logic [COUNT_BITS-1:0] vu_hit_cnt;
  logic [IW-1:0]         vu_vic_idx;
  logic                  vu_vic_wb;
  logic [BLK_W-1:0]      vu_vic_blk;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign in_ok      = 32'(in_data_i.block_number) < 32'(BLOCKS);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign idx        = cnt_q[IW-1:0];
  assign tm_bit     = tm_rd[blk_q[MAP_SH-1:0]];
  assign tm_wr_data = tm_rd | (MAP_WORD'(1) << blk_q[MAP_SH-1:0]);

  lbcp_touch_map #(
    .ROWS (ROWS)
  ) u_touch_map (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .busy_o    (tm_busy),
    .rd_en_i   (tm_rd_en),
    .rd_addr_i (RW'(32'(in_data_i.block_number) >> MAP_SH)),
    .rd_data_o (tm_rd),
    .wr_en_i   (tm_wr_en),
    .wr_addr_i (RW'(32'(blk_q) >> MAP_SH)),
    .wr_data_i (tm_wr_data)
  );

  lbcp_entry_ram #(
    .ENTRIES    (ENTRIES),
    .COUNT_BITS (COUNT_BITS)
  ) u_entry_ram (
    .clk_i     (clk_i),
    .rd_en_i   (er_rd_en),
    .rd_addr_i (idx),
    .rd_blk_o  (er_rd_blk),
    .rd_cnt_o  (er_rd_cnt),
    .wr_en_i   (er_wr_en),
    .wr_addr_i (er_wr_addr),
    .wr_blk_i  (blk_q),
    .wr_cnt_i  (er_wr_cnt)
  );

  lbcp_victim_unit #(
    .ENTRIES    (ENTRIES),
    .COUNT_BITS (COUNT_BITS)
  ) u_victim_unit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (vu_start),
    .step_i      (p_q),
    .idx_i       (p_idx_q),
    .ent_valid_i (valid_q[p_idx_q]),
    .ent_dirty_i (dirty_q[p_idx_q]),
    .ent_blk_i   (er_rd_blk),
    .ent_cnt_i   (valid_q[p_idx_q] ? er_rd_cnt : '0),
    .blk_i       (blk_q),
    .hit_o       (vu_hit),
    .hit_idx_o   (vu_hit_idx),
    .hit_cnt_o   (vu_hit_cnt),
    .vic_idx_o   (vu_vic_idx),
    .vic_wb_o    (vu_vic_wb),
    .vic_blk_o   (vu_vic_blk)
  );

  always_comb begin
    dirty_above = 1'b0;
    for (int k = 0; k < ENTRIES; k++) begin
      if (dirty_q[k] && (k > int'(idx))) dirty_above = 1'b1;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    valid_d    = valid_q;
    dirty_d    = dirty_q;
    tm_rd_en   = 1'b0;
    tm_wr_en   = 1'b0;
    er_rd_en   = 1'b0;
    er_wr_en   = 1'b0;
    er_wr_addr = vu_vic_idx;
    er_wr_cnt  = '0;
    vu_start   = 1'b0;
    out_load   = 1'b0;
    out_d      = '0;
    case (state_q)
      S_CLEAR: begin
        if (!tm_busy) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_fire) begin
          if (in_data_i.op == OP_FLUSH) begin
            cnt_d   = '0;
            state_d = S_FRD;
          end else if ((in_data_i.op inside {OP_READ, OP_WRITE}) && in_ok) begin
            tm_rd_en = 1'b1;
            state_d  = S_TOUCH;
          end
        end
      end
      S_TOUCH: begin
        if (op_q == OP_READ && !tm_bit) begin
          if (out_free) begin
            tm_wr_en        = 1'b1;
            out_load        = 1'b1;
            out_d.zero_fill = 1'b1;
            out_d.last      = 1'b1;
            state_d         = S_IDLE;
          end
        end else begin
          tm_wr_en = 1'b1;
          cnt_d    = '0;
          vu_start = 1'b1;
          state_d  = S_SCAN;
        end
      end
      S_SCAN: begin
        if (cnt_q < CW'(ENTRIES)) begin
          er_rd_en = 1'b1;
          cnt_d    = cnt_q + CW'(1);
        end else begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_d.last = 1'b1;
          state_d    = S_IDLE;
          if (vu_hit) begin
            out_d.hit         = 1'b1;
            out_d.entry_index = IDX_W'(vu_hit_idx);
            if (op_q == OP_READ) begin
              er_wr_en   = 1'b1;
              er_wr_addr = vu_hit_idx;
              er_wr_cnt  = (vu_hit_cnt == CNT_MAX) ? vu_hit_cnt
                                                   : vu_hit_cnt + COUNT_BITS'(1);
            end else begin
              dirty_d[vu_hit_idx] = 1'b1;
            end
          end else begin
            er_wr_en              = 1'b1;
            er_wr_addr            = vu_vic_idx;
            er_wr_cnt             = (op_q == OP_READ) ? '0 : COUNT_BITS'(1);
            valid_d[vu_vic_idx]   = 1'b1;
            dirty_d[vu_vic_idx]   = (op_q == OP_WRITE);
            out_d.entry_index     = IDX_W'(vu_vic_idx);
            out_d.fetch           = (op_q == OP_READ);
            out_d.write_back      = vu_vic_wb;
            out_d.write_back_block = vu_vic_wb ? vu_vic_blk : '0;
          end
        end
      end
      S_FRD: begin
        if (dirty_q[idx]) begin
          er_rd_en = 1'b1;
          state_d  = S_FOUT;
        end else if (cnt_q == CW'(ENTRIES - 1)) begin
          state_d = S_IDLE;
        end else begin
          cnt_d = cnt_q + CW'(1);
        end
      end
      S_FOUT: begin
        if (out_free) begin
          out_load               = 1'b1;
          out_d.entry_index      = IDX_W'(idx);
          out_d.write_back       = 1'b1;
          out_d.write_back_block = er_rd_blk;
          out_d.last             = !dirty_above;
          dirty_d[idx]           = 1'b0;
          if (dirty_above) begin
            cnt_d   = cnt_q + CW'(1);
            state_d = S_FRD;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      cnt_q       <= '0;
      valid_q     <= '0;
      dirty_q     <= '0;
      p_q         <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      valid_q <= valid_d;
      dirty_q <= dirty_d;
      p_q     <= er_rd_en && (state_q == S_SCAN);
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q  <= in_data_i.op;
      blk_q <= in_data_i.block_number;
    end
    p_idx_q <= idx;
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ hw/rtl/lbcp_checker.sv @@
`timescale 1ns / 1ps

module lbcp_checker import lbcp_pkg::*; #(
  parameter int ENTRIES = 20,
  parameter int BLOCKS = 32768
) (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input lbcp_in_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input lbcp_out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  a_busy_after_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o &&
    ((in_data_i.op == OP_FLUSH) ||
     (((in_data_i.op == OP_READ) || (in_data_i.op == OP_WRITE)) &&
      (32'(in_data_i.block_number) < 32'(BLOCKS))))
    |=> in_stall_o)
    else $error("request transfer not followed by busy");

  a_zero_fill_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.zero_fill |->
      !out_data_o.hit && !out_data_o.fetch && !out_data_o.write_back &&
      out_data_o.last && (out_data_o.entry_index == '0))
    else $error("zero-fill result carries other flags");

  a_flush_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last |->
      out_data_o.write_back && !out_data_o.hit && !out_data_o.fetch &&
      !out_data_o.zero_fill)
    else $error("non-final result is not a flush write-back");

  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(out_data_o.entry_index) < 32'(ENTRIES)))
    else $error("entry index out of range");

endmodule

bind lfu_block_cache_policy lbcp_checker #(
  .ENTRIES (ENTRIES),
  .BLOCKS  (BLOCKS)
) u_lbcp_checker (.*);
